>>> hdl/bdq_pkg.sv
package bdq_pkg;

	localparam int KIND_W   = 3;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_TOP    = 3'd0,
		KIND_PUSH_BOTTOM = 3'd1,
		KIND_POP_TOP     = 3'd2,
		KIND_POP_BOTTOM  = 3'd3,
		KIND_REVERSE     = 3'd4,
		KIND_SPLIT       = 3'd5
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_RESULT,
		CS_SPLIT_HI,
		CS_SPLIT_LO,
		CS_SPLIT_COPY
	} ctrl_state_t;

	typedef enum logic [1:0] {
		PH_HI,
		PH_LO,
		PH_COPY
	} scan_phase_t;

	typedef struct packed {
		logic        accept;
		logic        scan_en;
		scan_phase_t phase;
		logic        scan_restart;
		logic        load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} dp_stat_t;

endpackage

>>> hdl/bdq_req_if.sv
interface bdq_req_if
	import bdq_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [WORD_W-1:0] value;
	logic signed [WORD_W-1:0] threshold;

	modport source (output valid, kind, value, threshold, input ready);
	modport sink   (input valid, kind, value, threshold, output ready);
endinterface

>>> hdl/bdq_rsp_if.sv
interface bdq_rsp_if
	import bdq_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] popped;
	logic                     popped_valid;
	logic [STATUS_W-1:0]      status;
	logic [COUNT_W-1:0]       count;

	modport source (output valid, popped, popped_valid, status, count, input ready);
	modport sink   (input valid, popped, popped_valid, status, count, output ready);
endinterface

>>> hdl/bdq_ctrl.sv
module bdq_ctrl
	import bdq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [KIND_W-1:0] kind,
	output logic              req_ready,
	input  dp_stat_t          stat,
	output dp_cmd_t           cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (req_valid) begin
					state_d = (kind == KIND_SPLIT) ? CS_SPLIT_HI : CS_RESULT;
				end
			end
			CS_RESULT: begin
				if (stat.out_free) begin
					state_d = CS_IDLE;
				end
			end
			CS_SPLIT_HI: begin
				if (stat.scan_done) begin
					state_d = CS_SPLIT_LO;
				end
			end
			CS_SPLIT_LO: begin
				if (stat.scan_done) begin
					state_d = CS_SPLIT_COPY;
				end
			end
			CS_SPLIT_COPY: begin
				if (stat.scan_done) begin
					state_d = CS_RESULT;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		req_ready        = 1'b0;
		cmd.accept       = 1'b0;
		cmd.scan_en      = 1'b0;
		cmd.phase        = PH_HI;
		cmd.scan_restart = 1'b0;
		cmd.load_out     = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			CS_RESULT: begin
				cmd.load_out = stat.out_free;
			end
			CS_SPLIT_HI: begin
				cmd.scan_en      = 1'b1;
				cmd.phase        = PH_HI;
				cmd.scan_restart = stat.scan_done;
			end
			CS_SPLIT_LO: begin
				cmd.scan_en      = 1'b1;
				cmd.phase        = PH_LO;
				cmd.scan_restart = stat.scan_done;
			end
			CS_SPLIT_COPY: begin
				cmd.scan_en      = 1'b1;
				cmd.phase        = PH_COPY;
				cmd.scan_restart = stat.scan_done;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> hdl/bdq_dpath.sv
module bdq_dpath
	import bdq_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_stat_t                 stat,
	input  logic [KIND_W-1:0]        kind,
	input  logic signed [WORD_W-1:0] value,
	input  logic signed [WORD_W-1:0] threshold,
	input  logic                     rsp_ready,
	output logic                     rsp_valid,
	output logic signed [WORD_W-1:0] popped,
	output logic                     popped_valid,
	output logic [STATUS_W-1:0]      status,
	output logic [COUNT_W-1:0]       count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [DATA_WIDTH-1:0] store_mem   [DEPTH];
	logic [DATA_WIDTH-1:0] scratch_mem [DEPTH];

	logic [AW-1:0]         head_q;
	logic [CW-1:0]         cnt_q;
	logic                  rev_q;
	status_t               status_q;
	logic                  pvalid_q;
	logic [DATA_WIDTH-1:0] thr_q;
	logic [CW-1:0]         idx_q;
	logic [AW-1:0]         wn_q;
	logic                  scan_valid_s1;
	logic                  copy_valid_s1;
	logic [AW-1:0]         copy_addr_s1;
	logic [DATA_WIDTH-1:0] store_rd_q;
	logic [DATA_WIDTH-1:0] scratch_rd_q;

	logic                  out_valid_q;
	logic [WORD_W-1:0]     out_popped_q;
	logic                  out_pvalid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [COUNT_W-1:0]    out_count_q;

	logic [DATA_WIDTH+WORD_W-1:0] val_ext;
	logic [DATA_WIDTH+WORD_W-1:0] thr_ext;
	logic [DATA_WIDTH-1:0]        val_d;
	logic [DATA_WIDTH-1:0]        thr_d;
	logic [WORD_W+DATA_WIDTH-1:0] pop_ext;
	logic [CW+COUNT_W-1:0]        cnt_ext;

	logic          full;
	logic          empty;
	logic          push_low;
	logic          pop_low;
	logic [CW-1:0] cnt_m1;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] high_push_addr;
	logic [AW-1:0] high_pop_addr;
	logic [CW-1:0] scan_off;
	logic [AW-1:0] scan_slot;
	logic          scan_done;
	logic          issue;
	logic          at_or_above;

	logic                  store_we;
	logic [AW-1:0]         store_waddr;
	logic [DATA_WIDTH-1:0] store_wdata;
	logic                  store_re;
	logic [AW-1:0]         store_raddr;
	logic                  scratch_we;
	logic                  scratch_re;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	assign val_ext = {{DATA_WIDTH{value[WORD_W-1]}}, value};
	assign thr_ext = {{DATA_WIDTH{threshold[WORD_W-1]}}, threshold};
	assign val_d   = val_ext[DATA_WIDTH-1:0];
	assign thr_d   = thr_ext[DATA_WIDTH-1:0];

	assign full     = (cnt_q == FULL_CNT);
	assign empty    = (cnt_q == '0);
	assign push_low = (kind == KIND_PUSH_TOP) != rev_q;
	assign pop_low  = (kind == KIND_POP_TOP) != rev_q;
	assign cnt_m1   = cnt_q - CW'(1);
	assign head_dec = (head_q == '0) ? LAST_SLOT : head_q - AW'(1);
	assign head_inc = wrap_add(head_q, AW'(1));

	// A push or pop only reaches the high end with fewer than DEPTH entries
	// in the way, so the offset always fits the slot width.
	assign high_push_addr = wrap_add(head_q, cnt_q[AW-1:0]);
	assign high_pop_addr  = wrap_add(head_q, cnt_m1[AW-1:0]);

	// Logical position zero is the top; with the direction flag set the top
	// sits at the far end of the occupied run.
	assign scan_off  = rev_q ? (cnt_m1 - idx_q) : idx_q;
	assign scan_slot = wrap_add(head_q, scan_off[AW-1:0]);
	assign scan_done = (idx_q == cnt_q);
	assign issue     = cmd.scan_en && !scan_done;

	assign at_or_above = $signed(store_rd_q) >= $signed(thr_q);

	always_comb begin
		store_we    = 1'b0;
		store_waddr = head_q;
		store_wdata = val_d;
		store_re    = 1'b0;
		store_raddr = scan_slot;
		if (cmd.accept) begin
			case (kind)
				KIND_PUSH_TOP, KIND_PUSH_BOTTOM: begin
					if (!full) begin
						store_we    = 1'b1;
						store_waddr = push_low ? head_dec : high_push_addr;
					end
				end
				KIND_POP_TOP, KIND_POP_BOTTOM: begin
					if (!empty) begin
						store_re    = 1'b1;
						store_raddr = pop_low ? head_q : high_pop_addr;
					end
				end
				default: begin
					store_we = 1'b0;
				end
			endcase
		end
		if (copy_valid_s1) begin
			store_we    = 1'b1;
			store_waddr = copy_addr_s1;
			store_wdata = scratch_rd_q;
		end
		if (issue && cmd.phase != PH_COPY) begin
			store_re    = 1'b1;
			store_raddr = scan_slot;
		end
	end

	assign scratch_re = issue && (cmd.phase == PH_COPY);
	assign scratch_we = scan_valid_s1 && (at_or_above == (cmd.phase == PH_HI));

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_waddr] <= store_wdata;
		end
		if (store_re) begin
			store_rd_q <= store_mem[store_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (scratch_we) begin
			scratch_mem[wn_q] <= store_rd_q;
		end
		if (scratch_re) begin
			scratch_rd_q <= scratch_mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			cnt_q         <= '0;
			rev_q         <= 1'b0;
			status_q      <= ST_OK;
			pvalid_q      <= 1'b0;
			idx_q         <= '0;
			wn_q          <= '0;
			scan_valid_s1 <= 1'b0;
			copy_valid_s1 <= 1'b0;
		end else begin
			scan_valid_s1 <= issue && (cmd.phase != PH_COPY);
			copy_valid_s1 <= scratch_re;
			if (cmd.accept || cmd.scan_restart) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.accept) begin
				wn_q <= '0;
			end else if (scratch_we) begin
				wn_q <= wn_q + AW'(1);
			end
			if (cmd.accept) begin
				case (kind)
					KIND_PUSH_TOP, KIND_PUSH_BOTTOM: begin
						pvalid_q <= 1'b0;
						if (full) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_OK;
							cnt_q    <= cnt_q + CW'(1);
							if (push_low) begin
								head_q <= head_dec;
							end
						end
					end
					KIND_POP_TOP, KIND_POP_BOTTOM: begin
						if (empty) begin
							status_q <= ST_EMPTY;
							pvalid_q <= 1'b0;
						end else begin
							status_q <= ST_OK;
							pvalid_q <= 1'b1;
							cnt_q    <= cnt_m1;
							if (pop_low) begin
								head_q <= head_inc;
							end
						end
					end
					KIND_REVERSE: begin
						status_q <= ST_OK;
						pvalid_q <= 1'b0;
						rev_q    <= ~rev_q;
					end
					default: begin
						status_q <= ST_OK;
						pvalid_q <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			thr_q <= thr_d;
		end
		if (copy_valid_s1 || scratch_re) begin
			copy_addr_s1 <= scan_slot;
		end
	end

	assign pop_ext = {{WORD_W{store_rd_q[DATA_WIDTH-1]}}, store_rd_q};
	assign cnt_ext = {{COUNT_W{1'b0}}, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_popped_q <= pvalid_q ? pop_ext[WORD_W-1:0] : '0;
			out_pvalid_q <= pvalid_q;
			out_status_q <= status_q;
			out_count_q  <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign stat.scan_done = scan_done;
	assign stat.out_free  = !out_valid_q || rsp_ready;

	assign rsp_valid    = out_valid_q;
	assign popped       = out_popped_q;
	assign popped_valid = out_pvalid_q;
	assign status       = out_status_q;
	assign count        = out_count_q;

endmodule

>>> hdl/bounded_deque_with_reverse_split_unit.sv
// Bounded double-ended queue of signed words kept in a ring memory. One request
// names a push or pop at either end, a reverse or a stable split around a
// threshold, and each request returns exactly one response with the popped
// word, a status and the new count. Push, pop, reverse and the unused codes
// pass from acceptance through the result state into the output register;
// split first makes three passes over the entries (high part, low part,
// copy back) through the single read port of the entry memory and of the
// scratch memory, one entry a cycle. One request is in flight at a time; a new
// request is taken while the previous response still waits in the output
// register. The memories need no clearing after reset, since only occupied
// slots are ever read.
module bounded_deque_with_reverse_split_unit
	import bdq_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	bdq_req_if.sink    req,
	bdq_rsp_if.source  rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     ready;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.kind      (req.kind),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bdq_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (req.kind),
		.value        (req.value),
		.threshold    (req.threshold),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp.valid),
		.popped       (rsp.popped),
		.popped_valid (rsp.popped_valid),
		.status       (rsp.status),
		.count        (rsp.count)
	);

	assign req.ready = ready;

	// Only one request is worked on at a time.
	a_busy_after_accept: assert property (
		@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready
	) else $error("request accepted while the previous one was still in work");

	a_load_only_when_free: assert property (
		@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp.valid || rsp.ready)
	) else $error("response register overwritten before it was taken");

	a_popped_means_ok: assert property (
		@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.popped_valid) |-> (rsp.status == ST_OK)
	) else $error("popped word reported together with an error status");

	a_no_pop_zero_word: assert property (
		@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.popped_valid) |-> (rsp.popped == '0)
	) else $error("popped word is nonzero although nothing was removed");

endmodule

>>> tb/tb_bounded_deque_with_reverse_split_unit.sv
`timescale 1ns / 100ps

module tb_bounded_deque_with_reverse_split_unit
	import bdq_pkg::*;
();

	localparam int QDEPTH = 64;

	// The two codes the package leaves unnamed; the block treats them as no-ops.
	localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

	typedef struct packed {
		logic signed [WORD_W-1:0] popped;
		logic                     popped_valid;
		status_t                  status;
		logic [COUNT_W-1:0]       count;
	} deque_result_t;

	class deque_scoreboard;
		logic signed [WORD_W-1:0] ring [QDEPTH];
		int unsigned              head;
		int unsigned              fill;
		bit                       flipped;
		deque_result_t            awaited [$];
		int unsigned              mismatches;
		int unsigned              responses;
		int unsigned              kind_seen [8];
		int unsigned              full_hits;
		int unsigned              empty_hits;
		int unsigned              peak_fill;

		function new();
			head       = 0;
			fill       = 0;
			flipped    = 1'b0;
			mismatches = 0;
			responses  = 0;
			full_hits  = 0;
			empty_hits = 0;
			peak_fill  = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
		endfunction

		// Ring slot of logical position pos, counted from the top.
		function int unsigned slot(int unsigned pos);
			int unsigned off;
			off = flipped ? fill - 1 - pos : pos;
			return (head + off) % QDEPTH;
		endfunction

		function logic signed [WORD_W-1:0] any_entry();
			if (fill == 0) begin
				return $urandom;
			end
			return ring[slot($urandom_range(0, fill - 1))];
		endfunction

		function void note_request(logic [KIND_W-1:0] kind, logic signed [WORD_W-1:0] value,
				logic signed [WORD_W-1:0] threshold);
			deque_result_t            want;
			logic signed [WORD_W-1:0] upper [$];
			logic signed [WORD_W-1:0] lower [$];
			logic signed [WORD_W-1:0] word;
			bit                       at_low;
			int unsigned              i;
			want.popped       = '0;
			want.popped_valid = 1'b0;
			want.status       = ST_OK;
			kind_seen[kind]++;
			case (kind)
			KIND_PUSH_TOP, KIND_PUSH_BOTTOM: begin
				// When the direction flag is set, the top lives at the high end.
				at_low = (kind == KIND_PUSH_TOP) != flipped;
				if (fill >= QDEPTH) begin
					want.status = ST_FULL;
					full_hits++;
				end else if (at_low) begin
					head       = (head + QDEPTH - 1) % QDEPTH;
					ring[head] = value;
					fill++;
				end else begin
					ring[(head + fill) % QDEPTH] = value;
					fill++;
				end
			end
			KIND_POP_TOP, KIND_POP_BOTTOM: begin
				at_low = (kind == KIND_POP_TOP) != flipped;
				if (fill == 0) begin
					want.status = ST_EMPTY;
					empty_hits++;
				end else begin
					if (at_low) begin
						word = ring[head];
						head = (head + 1) % QDEPTH;
					end else begin
						word = ring[(head + fill - 1) % QDEPTH];
					end
					fill--;
					want.popped       = word;
					want.popped_valid = 1'b1;
				end
			end
			KIND_REVERSE: begin
				flipped = !flipped;
			end
			KIND_SPLIT: begin
				for (i = 0; i < fill; i++) begin
					word = ring[slot(i)];
					if (word >= threshold) upper.push_back(word);
					else lower.push_back(word);
				end
				upper = {upper, lower};
				for (i = 0; i < fill; i++) begin
					ring[slot(i)] = upper[i];
				end
			end
			default: begin
			end
			endcase
			if (fill > peak_fill) peak_fill = fill;
			want.count = COUNT_W'(fill);
			awaited.push_back(want);
		endfunction

		function string show(deque_result_t r);
			return $sformatf("popped=%0d popped_valid=%0b status=%0d count=%0d",
				r.popped, r.popped_valid, r.status, r.count);
		endfunction

		function void check_response(deque_result_t got);
			deque_result_t want;
			responses++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] response with no request outstanding: %s",
						$time, show(got));
				end
				return;
			end
			want = awaited.pop_front();
			if (got.popped !== want.popped || got.popped_valid !== want.popped_valid ||
					got.status !== want.status || got.count !== want.count) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] response %0d differs: expected %s, got %s",
						$time, responses, show(want), show(got));
				end
			end
		endfunction
	endclass

	typedef enum {EP_MIX, EP_GROW, EP_SHRINK, EP_SPLIT} episode_t;

	localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic signed [WORD_W-1:0] WORD_MAX = ~WORD_MIN;
	localparam int ITEM_TARGET = 1950;
	localparam int QUIET_TAIL  = 300;
	localparam int LONG_HOLD   = 400;
	localparam int SETTLE      = 40;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n;

	bdq_req_if req_if ();
	bdq_rsp_if rsp_if ();

	deque_scoreboard queue_model = new();

	int unsigned items_sent = 0;
	int unsigned cycles     = 0;
	bit          gaps_on    = 1'b1;
	bit          stalls_on  = 1'b1;
	bit          long_hold_req = 1'b0;

	bounded_deque_with_reverse_split_unit #(
		.DEPTH      (QDEPTH),
		.DATA_WIDTH (WORD_W)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			cycles++;
			if (rsp_if.valid && rsp_if.ready) begin
				queue_model.check_response('{rsp_if.popped, rsp_if.popped_valid,
					status_t'(rsp_if.status), rsp_if.count});
			end
			if (req_if.valid && req_if.ready) begin
				queue_model.note_request(req_if.kind, req_if.value, req_if.threshold);
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("run stopped after %0d cycles with %0d responses outstanding",
					cycles, queue_model.awaited.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Response side: random stall bursts, plus one long hold-off on request.
	initial begin
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (stalls_on && $urandom_range(0, 4) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
		0:       return WORD_MIN;
		1:       return WORD_MAX;
		2:       return '0;
		3:       return '1;
		// Small values repeat often, which makes the stable order of a split visible.
		4, 5:    return WORD_W'(int'($urandom_range(0, 15)) - 8);
		default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [WORD_W-1:0] pick_threshold();
		if ($urandom_range(0, 1)) return queue_model.any_entry();
		return pick_word();
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind(episode_t mode);
		int unsigned roll;
		int unsigned push_pct;
		int unsigned pop_pct;
		int unsigned flip_pct;
		roll = $urandom_range(0, 99);
		case (mode)
		EP_GROW:   begin push_pct = 85; pop_pct = 7;  flip_pct = 4;  end
		EP_SHRINK: begin push_pct = 8;  pop_pct = 80; flip_pct = 6;  end
		EP_SPLIT:  begin push_pct = 45; pop_pct = 10; flip_pct = 10; end
		default:   begin push_pct = 38; pop_pct = 30; flip_pct = 10; end
		endcase
		if (roll == 99) return $urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7;
		if (roll < push_pct) return $urandom_range(0, 1) ? KIND_PUSH_TOP : KIND_PUSH_BOTTOM;
		roll -= push_pct;
		if (roll < pop_pct) return $urandom_range(0, 1) ? KIND_POP_TOP : KIND_POP_BOTTOM;
		roll -= pop_pct;
		if (roll < flip_pct) return KIND_REVERSE;
		return KIND_SPLIT;
	endfunction

	// Called on a rising edge; returns on the edge where the request is taken, or after an idle gap that follows it.
	task automatic send_request(input logic [KIND_W-1:0] kind,
			input logic signed [WORD_W-1:0] value, input logic signed [WORD_W-1:0] threshold);
		req_if.valid     <= 1'b1;
		req_if.kind      <= kind;
		req_if.value     <= value;
		req_if.threshold <= threshold;
		do @(posedge clk); while (!req_if.ready);
		if (kind != KIND_SPARE_6 && kind != KIND_SPARE_7) items_sent++;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// The extra edge lets the monitor note a request taken on the current edge.
	task automatic wait_for_drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (queue_model.awaited.size() != 0) @(posedge clk);
	endtask

	task automatic run_directed();
		send_request(KIND_POP_TOP,     pick_word(), pick_word());
		send_request(KIND_POP_BOTTOM,  pick_word(), pick_word());
		send_request(KIND_REVERSE,     pick_word(), pick_word());
		send_request(KIND_SPLIT,       pick_word(), '0);
		send_request(KIND_SPARE_6,     pick_word(), pick_word());
		send_request(KIND_SPARE_7,     pick_word(), pick_word());
		send_request(KIND_PUSH_TOP,    WORD_MAX, pick_word());
		send_request(KIND_PUSH_BOTTOM, WORD_MIN, pick_word());
		send_request(KIND_PUSH_TOP,    '1, pick_word());
		send_request(KIND_PUSH_BOTTOM, '0, pick_word());
		send_request(KIND_PUSH_TOP,    1, pick_word());
		send_request(KIND_PUSH_BOTTOM, 32'sh5555_5555, pick_word());
		send_request(KIND_SPLIT,       pick_word(), '0);
		send_request(KIND_REVERSE,     pick_word(), pick_word());
		send_request(KIND_SPLIT,       pick_word(), WORD_MIN);
		send_request(KIND_SPLIT,       pick_word(), WORD_MAX);
		send_request(KIND_SPLIT,       pick_word(), '1);
		send_request(KIND_POP_TOP,     pick_word(), pick_word());
		send_request(KIND_POP_BOTTOM,  pick_word(), pick_word());
		send_request(KIND_REVERSE,     pick_word(), pick_word());
		send_request(KIND_POP_TOP,     pick_word(), pick_word());
		send_request(KIND_POP_BOTTOM,  pick_word(), pick_word());
		send_request(KIND_POP_TOP,     pick_word(), pick_word());
		send_request(KIND_POP_TOP,     pick_word(), pick_word());
		send_request(KIND_POP_BOTTOM,  pick_word(), pick_word());
	endtask

	initial begin
		episode_t          mode;
		int unsigned       span;
		logic [KIND_W-1:0] kind;
		bit                hold_done;
		bit                drain_done;
		hold_done        = 1'b0;
		drain_done       = 1'b0;
		req_if.valid     = 1'b0;
		req_if.kind      = '0;
		req_if.value     = '0;
		req_if.threshold = '0;
		arst_n           = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_for_drain();

		while (items_sent < ITEM_TARGET) begin
			if (items_sent + QUIET_TAIL >= ITEM_TARGET) begin
				gaps_on   = 1'b0;
				stalls_on = 1'b0;
			end else begin
				gaps_on   = $urandom_range(0, 3) != 0;
				stalls_on = $urandom_range(0, 3) != 0;
			end
			// Hold the response side off while requests keep coming, so the block backs up.
			if (!hold_done && items_sent >= 600) begin
				hold_done     = 1'b1;
				long_hold_req = 1'b1;
			end
			if (!drain_done && items_sent >= 1200) begin
				drain_done = 1'b1;
				wait_for_drain();
			end
			mode = episode_t'($urandom_range(0, 3));
			span = (mode == EP_GROW || mode == EP_SHRINK) ? 90 : 30;
			repeat (span) begin
				kind = pick_kind(mode);
				send_request(kind, pick_word(), pick_threshold());
			end
		end

		wait_for_drain();
		repeat (SETTLE) @(posedge clk);

		$display("%0d requests: push %0d/%0d, pop %0d/%0d, reverse %0d, split %0d, unused %0d",
			items_sent,
			queue_model.kind_seen[KIND_PUSH_TOP], queue_model.kind_seen[KIND_PUSH_BOTTOM],
			queue_model.kind_seen[KIND_POP_TOP], queue_model.kind_seen[KIND_POP_BOTTOM],
			queue_model.kind_seen[KIND_REVERSE], queue_model.kind_seen[KIND_SPLIT],
			queue_model.kind_seen[KIND_SPARE_6] + queue_model.kind_seen[KIND_SPARE_7]);
		$display("peak fill %0d, %0d pushes on a full queue, %0d pops on an empty one, %0d %s",
			queue_model.peak_fill, queue_model.full_hits, queue_model.empty_hits,
			queue_model.mismatches, "mismatches");
		if (queue_model.mismatches == 0 && queue_model.awaited.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
